// ===== sv/md5_pkg.sv =====
// ----------------------------------------------------------------------------
// MD5 package
// Step constants, rotate amounts, message schedule and sequencer states.
// ----------------------------------------------------------------------------
package md5_pkg;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PAD,
    ST_COMP,
    ST_FIN
  } md5_state_t;

  localparam logic [31:0] CHAIN_INIT [4] = '{
    32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476
  };

  localparam logic [31:0] PAD_BYTE = 32'h00000080;

  localparam logic [31:0] STEP_K [64] = '{
    32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
    32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
    32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
    32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
    32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
    32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
    32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
    32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
    32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
    32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
    32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
    32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
    32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
    32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
    32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
    32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
  };

  localparam logic [4:0] ROT_AMT [16] = '{
    5'd7, 5'd12, 5'd17, 5'd22,
    5'd5, 5'd9,  5'd14, 5'd20,
    5'd4, 5'd11, 5'd16, 5'd23,
    5'd6, 5'd10, 5'd15, 5'd21
  };

  // Message word used by step j.
  function automatic logic [3:0] md5_g(input logic [5:0] j);
    logic [3:0] jl;
    logic [3:0] g;
    jl = j[3:0];
    unique case (j[5:4])
      2'd0: g = jl;
      2'd1: g = 4'((jl << 2) + jl + 4'd1);
      2'd2: g = 4'((jl << 1) + jl + 4'd5);
      default: g = 4'((jl << 3) - jl);
    endcase
    return g;
  endfunction

endpackage

// ===== sv/md5_ram.sv =====
// ----------------------------------------------------------------------------
// MD5 RAM
// Generic single-write, single-read memory with registered read data.
// ----------------------------------------------------------------------------
module md5_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/md5_message_digest.sv =====
// ----------------------------------------------------------------------------
// MD5 message digest
// Buffers 16-word blocks, pads the message and runs the 64-step compression.
// ----------------------------------------------------------------------------
//
//  channel   dir  bits                                       end marker
//  s_*       in   tdata[31:0] data_word, [34:32] byte_count   tlast = last
//  m_*       out  tdata[31:0] digest_word, tuser word_index   tlast = final_word
//
//  A word that does not end a block is taken while idle. The sixteenth word
//  of a block starts the compression: one step per cycle through a single
//  step adder, with the block buffer read at the start and the chaining add
//  at the end of each block. Padding writes one word per cycle, then one or two
//  more blocks run. The four digest words are held in an output register, so
//  the next message is taken while they wait; a second digest waits for them.
//  rst resets the sequencer and chaining words; the block buffer needs none.
//
module md5_message_digest (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // [31:0] data_word, [34:32] byte_count, rest zero
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [31:0] digest_word
  output logic [1:0]  m_tuser,   // [1:0] word_index
  output logic        m_tlast
);

  import md5_pkg::*;

  md5_state_t state, state_next;

  logic [3:0]  pos;
  logic [63:0] bit_len;
  logic        tail;
  logic        pend80;
  logic        lo_done;
  logic        hi_done;
  logic [6:0]  cyc;
  logic [31:0] chain [4];
  logic [31:0] a, b, c, d;
  logic [31:0] pre;
  logic [31:0] out_word [4];
  logic [1:0]  out_idx;
  logic        out_busy;

  logic        in_acc;
  logic        out_acc;
  logic [31:0] in_data;
  logic [2:0]  cnt;
  logic [31:0] last_word;
  logic [31:0] pad_word;
  logic        ram_we;
  logic [3:0]  ram_waddr;
  logic [31:0] ram_wdata;
  logic [3:0]  ram_raddr;
  logic [31:0] ram_rdata;
  logic [5:0]  j1;
  logic [5:0]  j2;
  logic [31:0] f;
  logic [31:0] sum;
  logic [63:0] rot2;
  logic [31:0] b_new;
  logic        pre_en;
  logic        step_en;

  assign in_data = s_tdata[31:0];
  assign cnt     = (s_tdata[34:32] > 3'd4) ? 3'd4 : s_tdata[34:32];
  assign in_acc  = s_tvalid && s_tready;
  assign out_acc = m_tvalid && m_tready;

  assign m_tvalid = out_busy;
  assign m_tdata  = out_word[out_idx];
  assign m_tuser  = out_idx;
  assign m_tlast  = (out_idx == 2'd3);

  // Mask off unused bytes of the last word and place the 0x80 marker; a full word defers it to padding.
  always_comb begin
    unique case (cnt)
      3'd0:    last_word = PAD_BYTE;
      3'd1:    last_word = {16'h0000, 8'h80, in_data[7:0]};
      3'd2:    last_word = {8'h00, 8'h80, in_data[15:0]};
      3'd3:    last_word = {8'h80, in_data[23:0]};
      default: last_word = in_data;
    endcase
  end

  always_comb begin
    priority if (pend80) begin
      pad_word = PAD_BYTE;
    end else if (pos == 4'd14) begin
      pad_word = bit_len[31:0];
    end else if (pos == 4'd15 && lo_done) begin
      pad_word = bit_len[63:32];
    end else begin
      pad_word = '0;
    end
  end

  assign ram_we    = in_acc || (state == ST_PAD);
  assign ram_waddr = pos;
  assign ram_wdata = (state == ST_PAD) ? pad_word : (s_tlast ? last_word : in_data);
  assign ram_raddr = md5_g(cyc[5:0]);

  md5_ram #(
    .WIDTH(32),
    .DEPTH(16)
  ) u_buf (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // The operand sum a + K + M of step j1 is registered in pre in the cycle before step j2 uses it and rotates.
  assign j1      = 6'(cyc - 7'd1);
  assign j2      = 6'(cyc - 7'd2);
  assign pre_en  = (state == ST_COMP) && (cyc >= 7'd1) && (cyc <= 7'd64);
  assign step_en = (state == ST_COMP) && (cyc >= 7'd2) && (cyc <= 7'd65);

  always_comb begin
    unique case (j2[5:4])
      2'd0:    f = (b & c) | (~b & d);
      2'd1:    f = (b & d) | (c & ~d);
      2'd2:    f = b ^ c ^ d;
      default: f = c ^ (b | ~d);
    endcase
    sum   = pre + f;
    rot2  = {sum, sum} << ROT_AMT[{j2[5:4], j2[1:0]}];
    b_new = b + rot2[63:32];
  end

  // Sequencer.
  always_comb begin
    state_next = state;
    s_tready   = 1'b0;
    unique case (state)
      ST_IDLE: begin
        s_tready = 1'b1;
        if (in_acc) begin
          if (pos == 4'd15) begin
            state_next = ST_COMP;
          end else if (s_tlast) begin
            state_next = ST_PAD;
          end
        end
      end
      ST_PAD: begin
        if (pos == 4'd15) begin
          state_next = ST_COMP;
        end
      end
      ST_COMP: begin
        if (cyc == 7'd66) begin
          priority if (hi_done) begin
            state_next = ST_FIN;
          end else if (tail) begin
            state_next = ST_PAD;
          end else begin
            state_next = ST_IDLE;
          end
        end
      end
      ST_FIN: begin
        if (!out_busy) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Control and chaining state.
  always_ff @(posedge clk) begin
    if (rst) begin
      pos      <= '0;
      bit_len  <= '0;
      tail     <= 1'b0;
      pend80   <= 1'b0;
      lo_done  <= 1'b0;
      hi_done  <= 1'b0;
      cyc      <= '0;
      chain    <= CHAIN_INIT;
      out_busy <= 1'b0;
      out_idx  <= '0;
    end else begin
      if (out_acc) begin
        out_idx <= out_idx + 2'd1;
        if (out_idx == 2'd3) begin
          out_busy <= 1'b0;
        end
      end
      unique case (state)
        ST_IDLE: begin
          cyc <= '0;
          if (in_acc) begin
            pos <= pos + 4'd1;
            if (s_tlast) begin
              bit_len <= bit_len + {58'd0, cnt, 3'd0};
              tail    <= 1'b1;
              pend80  <= (cnt == 3'd4);
            end else begin
              bit_len <= bit_len + 64'd32;
            end
          end
        end
        ST_PAD: begin
          cyc <= '0;
          pos <= pos + 4'd1;
          priority if (pend80) begin
            pend80 <= 1'b0;
          end else if (pos == 4'd14) begin
            lo_done <= 1'b1;
          end else if (pos == 4'd15 && lo_done) begin
            hi_done <= 1'b1;
          end else begin
            pend80 <= 1'b0;
          end
        end
        ST_COMP: begin
          cyc <= cyc + 7'd1;
          if (cyc == 7'd66) begin
            chain[0] <= chain[0] + a;
            chain[1] <= chain[1] + b;
            chain[2] <= chain[2] + c;
            chain[3] <= chain[3] + d;
          end
        end
        ST_FIN: begin
          if (!out_busy) begin
            out_busy <= 1'b1;
            out_idx  <= '0;
            chain    <= CHAIN_INIT;
            bit_len  <= '0;
            tail     <= 1'b0;
            pend80   <= 1'b0;
            lo_done  <= 1'b0;
            hi_done  <= 1'b0;
          end
        end
        default: cyc <= '0;
      endcase
    end
  end

  // Working variables and output words.
  always_ff @(posedge clk) begin
    if (state != ST_COMP) begin
      a <= chain[0];
      b <= chain[1];
      c <= chain[2];
      d <= chain[3];
    end else if (step_en) begin
      a <= d;
      b <= b_new;
      c <= b;
      d <= c;
    end
    if (pre_en) begin
      // Step zero takes a directly; later steps take d, which becomes their a.
      pre <= ((j1 == 6'd0) ? a : d) + STEP_K[j1] + ram_rdata;
    end
    if (state == ST_FIN && !out_busy) begin
      out_word <= chain;
    end
  end

endmodule
